// ===== design/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked at every edge out of reset
`define TCH_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked at every edge, reset included
`define TCH_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/tch_pkg.sv =====
package tch_pkg;

  localparam logic [31:0] DIST_MAX = 32'hFFFF_FFFF;
  localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
  localparam logic [31:0] THREE_Q30 = 32'hC000_0000;
  localparam logic [31:0] K_ANGLE = 32'h28BE_60DB;
  localparam logic [31:0] RADIUS_RESET = 32'h0001_0000;

  typedef enum logic [2:0] {
    REG_RADIUS,
    REG_SPIRAL_LENGTH,
    REG_ARC_LENGTH,
    REG_SWEEP_ANGLE,
    REG_START_HEADING,
    REG_TURN_NEGATIVE,
    REG_SPEED,
    REG_LEAD_TIME
  } reg_index_t;

  typedef enum logic [2:0] {
    H_ZERO,
    H_SWEEP,
    H_BARE,
    H_ENTRY,
    H_ARC,
    H_EXIT
  } hreg_t;

  typedef struct packed {
    logic [31:0]        radius;
    logic [31:0]        spiral_length;
    logic [31:0]        arc_length;
    logic [47:0]        sweep_angle;
    logic signed [31:0] start_heading;
    logic               turn_negative;
    logic [22:0]        speed;
    logic [19:0]        lead_time;
  } cfg_t;

  typedef struct packed {
    logic        cz;
    logic        use_one;
    logic        ge;
    hreg_t       hreg;
    logic [32:0] dval;
    logic [31:0] curv;
  } ev_side_t;

  typedef struct packed {
    logic [31:0] s;
    logic [26:0] full;
    logic        use_full;
  } ld_side_t;

endpackage

// ===== design/tch_div.sv =====
`include "assert_macros.svh"

module tch_div #(
  parameter int NW = 64,
  parameter int DW = 32,
  parameter int QW = 32,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_vld,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  input  logic [SW-1:0] side_in,
  output logic          out_vld,
  output logic [QW-1:0] quo,
  output logic [SW-1:0] side_out
);

  logic          vl [QW];
  logic [QW-1:0] qt [QW];
  logic [SW-1:0] sd [QW];
  logic [NW-1:0] rm [QW-1];
  logic [DW-1:0] dn [QW-1];

  for (genvar g = 0; g < QW; g++) begin : g_stage
    localparam int SH = QW - 1 - g;
    logic          v_i;
    logic [NW-1:0] r_i;
    logic [QW-1:0] q_i;
    logic [DW-1:0] d_i;
    logic [SW-1:0] s_i;
    logic          fits;

    if (g == 0) begin : g_first
      assign v_i = in_vld;
      assign r_i = num;
      assign q_i = '0;
      assign d_i = den;
      assign s_i = side_in;
    end else begin : g_next
      assign v_i = vl[g-1];
      assign r_i = rm[g-1];
      assign q_i = qt[g-1];
      assign d_i = dn[g-1];
      assign s_i = sd[g-1];
    end

    assign fits = (r_i >> SH) >= NW'(d_i);

    always_ff @(posedge clk) begin
      if (rst) begin
        vl[g] <= 1'b0;
      end else if (en) begin
        vl[g] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        qt[g] <= q_i | (fits ? (QW'(1) << SH) : QW'(0));
        sd[g] <= s_i;
      end
    end

    if (g < QW - 1) begin : g_keep
      always_ff @(posedge clk) begin
        if (en) begin
          rm[g] <= fits ? r_i - (NW'(d_i) << SH) : r_i;
          dn[g] <= d_i;
        end
      end
    end
  end

  assign out_vld  = vl[QW-1];
  assign quo      = qt[QW-1];
  assign side_out = sd[QW-1];

  `TCH_ASSERT(a_div_hold, !en |=> $stable(quo), "quotient moved while the pipe was held")

endmodule

// ===== design/tch_eval.sv =====
module tch_eval (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_vld,
  input  logic [31:0]   x,
  input  tch_pkg::cfg_t cfg,
  output logic          out_vld,
  output logic [31:0]   curv,
  output logic [31:0]   heading
);

  localparam int SIDE_W = $bits(tch_pkg::ev_side_t);

  // stage 0: turn length
  logic        v0;
  logic [31:0] x0, t0;
  logic [32:0] la0;
  logic [33:0] sum_t;

  assign sum_t = 34'({cfg.spiral_length, 1'b0}) + 34'(cfg.arc_length);

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en) begin
      v0 <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x0  <= x;
      t0  <= (sum_t[33:32] != 2'b00) ? tch_pkg::DIST_MAX : sum_t[31:0];
      la0 <= 33'(cfg.spiral_length) + 33'(cfg.arc_length);
    end
  end

  // stage 1: regions
  logic                v1;
  logic [31:0]         num1, num_u;
  tch_pkg::ev_side_t   side1, side1_next;
  logic                entry, no_l;

  assign no_l  = cfg.spiral_length == 32'd0;
  assign entry = x0 <= cfg.spiral_length;
  assign num_u = entry ? x0 : t0 - x0;

  always_comb begin
    side1_next         = '0;
    side1_next.cz      = (cfg.radius == 32'd0) || (x0 == 32'd0) || (x0 >= t0);
    side1_next.use_one = no_l || (!entry && (33'(x0) < la0));
    side1_next.ge      = num_u >= cfg.spiral_length;
    side1_next.dval    = no_l ? 33'(x0)
                              : 33'(cfg.spiral_length[31:1]) + 33'(x0 - cfg.spiral_length);
    if ((cfg.radius == 32'd0) || (x0 == 32'd0)) begin
      side1_next.hreg = tch_pkg::H_ZERO;
    end else if (x0 >= t0) begin
      side1_next.hreg = tch_pkg::H_SWEEP;
    end else if (no_l) begin
      side1_next.hreg = tch_pkg::H_BARE;
    end else if (entry) begin
      side1_next.hreg = tch_pkg::H_ENTRY;
    end else if (33'(x0) <= la0) begin
      side1_next.hreg = tch_pkg::H_ARC;
    end else begin
      side1_next.hreg = tch_pkg::H_EXIT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= v0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num1  <= num_u;
      side1 <= side1_next;
    end
  end

  // normalized position
  logic              vu;
  logic [29:0]       uq;
  tch_pkg::ev_side_t sideu;

  tch_div #(.NW(62), .DW(32), .QW(30), .SW(SIDE_W)) u_div_u (
    .clk, .rst, .en,
    .in_vld(v1), .num({num1, 30'd0}), .den(cfg.spiral_length), .side_in(side1),
    .out_vld(vu), .quo(uq), .side_out(sideu)
  );

  // polynomial stages
  logic [30:0] u;
  logic [61:0] sq;
  assign u  = sideu.ge ? tch_pkg::ONE_Q30 : {1'b0, uq};
  assign sq = 62'(u) * 62'(u);

  logic              vp1, vp2, vp3, vp4, vp5;
  logic [30:0]       u_1, u2_1, u_2, u3_2, ss_2, u3_3, u4_3, ss_3, si_4, sc_4, sc_5;
  tch_pkg::ev_side_t sd_1, sd_2, sd_3, sd_4, sd_5, sd_5_next;
  logic [61:0]       cube, quart;
  logic [62:0]       smp, dm;
  logic [31:0]       tw;

  assign cube  = 62'(u2_1) * 62'(u_1);
  assign tw    = tch_pkg::THREE_Q30 - {u_1, 1'b0};
  assign smp   = 63'(u2_1) * 63'(tw);
  assign quart = 62'(u3_2) * 62'(u_2);
  assign dm    = 63'(cfg.spiral_length) * 63'(si_4);

  always_comb begin
    sd_5_next = sd_4;
    if ((sd_4.hreg == tch_pkg::H_ENTRY) || (sd_4.hreg == tch_pkg::H_EXIT)) begin
      sd_5_next.dval = dm[62:30];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vp1 <= 1'b0;
      vp2 <= 1'b0;
      vp3 <= 1'b0;
      vp4 <= 1'b0;
      vp5 <= 1'b0;
    end else if (en) begin
      vp1 <= vu;
      vp2 <= vp1;
      vp3 <= vp2;
      vp4 <= vp3;
      vp5 <= vp4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      u_1  <= u;
      u2_1 <= sq[60:30];
      sd_1 <= sideu;
      u_2  <= u_1;
      u3_2 <= cube[60:30];
      ss_2 <= smp[60:30];
      sd_2 <= sd_1;
      u3_3 <= u3_2;
      u4_3 <= quart[60:30];
      ss_3 <= ss_2;
      sd_3 <= sd_2;
      si_4 <= u3_3 - (u4_3 >> 1);
      sc_4 <= sd_3.use_one ? tch_pkg::ONE_Q30 : ss_3;
      sd_4 <= sd_3;
      sc_5 <= sc_4;
      sd_5 <= sd_5_next;
    end
  end

  // curvature quotient
  logic              vc;
  logic [40:0]       cq;
  tch_pkg::ev_side_t sidec, sidec_set;

  tch_div #(.NW(41), .DW(32), .QW(41), .SW(SIDE_W)) u_div_c (
    .clk, .rst, .en,
    .in_vld(vp5), .num({sc_5, 10'd0}), .den(cfg.radius), .side_in(sd_5),
    .out_vld(vc), .quo(cq), .side_out(sidec)
  );

  always_comb begin
    sidec_set = sidec;
    if (sidec.cz) begin
      sidec_set.curv = 32'd0;
    end else if (cq[40:32] != 9'd0) begin
      sidec_set.curv = tch_pkg::DIST_MAX;
    end else begin
      sidec_set.curv = cq[31:0];
    end
  end

  // swept distance over radius, 32 fraction bits
  logic              va;
  logic [64:0]       aq;
  tch_pkg::ev_side_t sidea;

  tch_div #(.NW(65), .DW(32), .QW(65), .SW(SIDE_W)) u_div_a (
    .clk, .rst, .en,
    .in_vld(vc), .num({sidec.dval, 32'd0}), .den(cfg.radius), .side_in(sidec_set),
    .out_vld(va), .quo(aq), .side_out(sidea)
  );

  // angle scaling and heading
  logic              vm1, vm2;
  logic [63:0]       pq, pf;
  logic [31:0]       a1, a2, ang, swept;
  tch_pkg::ev_side_t sd_m;

  assign pq  = 64'(aq[31+32:32]) * 64'(tch_pkg::K_ANGLE);
  assign pf  = 64'(aq[31:0]) * 64'(tch_pkg::K_ANGLE);
  assign ang = a1 + a2;

  always_comb begin
    case (sd_m.hreg)
      tch_pkg::H_ZERO:  swept = 32'd0;
      tch_pkg::H_SWEEP: swept = cfg.sweep_angle[31:0];
      tch_pkg::H_EXIT:  swept = cfg.sweep_angle[31:0] - ang;
      default:          swept = ang;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vm1 <= 1'b0;
      vm2 <= 1'b0;
    end else if (en) begin
      vm1 <= va;
      vm2 <= vm1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a1      <= pq[31:0];
      a2      <= pf[63:32];
      sd_m    <= sidea;
      curv    <= sd_m.curv;
      heading <= cfg.turn_negative ? cfg.start_heading - swept
                                   : cfg.start_heading + swept;
    end
  end

  assign out_vld = vm2;

endmodule

// ===== design/transition_curve_heading_profile_top.sv =====
// Curvature, heading and look-ahead heading rate along a smoothstep transition
// turn. One distance request is taken every clock while no held result stalls
// the pipe, and each gives one result. The look-ahead point is formed first
// (one 27-stage bit-per-cycle divider by the transition length), then the
// distance and the look-ahead point are evaluated side by side (dividers of
// 30, 41 and 65 stages, one quotient bit each, plus multiplier stages), and
// last the rate and the result register are formed. A held result stalls the
// whole pipe; nothing is lost or repeated. Write registers only while no
// request is in flight.
`include "assert_macros.svh"

module transition_curve_heading_profile_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               path_valid,
  output logic               path_stall,
  input  logic [31:0]        path_distance,
  output logic               result_valid,
  input  logic               result_stall,
  output logic [31:0]        curvature,
  output logic signed [31:0] path_heading,
  output logic signed [31:0] track_heading,
  output logic signed [31:0] track_heading_rate,
  input  logic               write_enable,
  input  logic [2:0]         register_index,
  input  logic [47:0]        write_data
);

  localparam int LD_W = $bits(tch_pkg::ld_side_t);

  tch_pkg::cfg_t cfg;
  logic          en;

  assign en         = !(result_valid && result_stall);
  assign path_stall = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= {tch_pkg::RADIUS_RESET, {($bits(tch_pkg::cfg_t) - 32){1'b0}}};
    end else if (write_enable) begin
      case (tch_pkg::reg_index_t'(register_index))
        tch_pkg::REG_RADIUS:        cfg.radius        <= write_data[31:0];
        tch_pkg::REG_SPIRAL_LENGTH: cfg.spiral_length <= write_data[31:0];
        tch_pkg::REG_ARC_LENGTH:    cfg.arc_length    <= write_data[31:0];
        tch_pkg::REG_SWEEP_ANGLE:   cfg.sweep_angle   <= write_data;
        tch_pkg::REG_START_HEADING: cfg.start_heading <= write_data[31:0];
        tch_pkg::REG_TURN_NEGATIVE: cfg.turn_negative <= write_data[0];
        tch_pkg::REG_SPEED:         cfg.speed         <= write_data[22:0];
        tch_pkg::REG_LEAD_TIME:     cfg.lead_time     <= write_data[19:0];
        default: ;
      endcase
    end
  end

  // look-ahead stage 0
  logic        lv0;
  logic [31:0] ls0, lt0;
  logic [32:0] lla0;
  logic [26:0] full0;
  logic [42:0] fprod;
  logic [33:0] lsum_t;

  assign fprod  = 43'(cfg.speed) * 43'(cfg.lead_time);
  assign lsum_t = 34'({cfg.spiral_length, 1'b0}) + 34'(cfg.arc_length);

  always_ff @(posedge clk) begin
    if (rst) begin
      lv0 <= 1'b0;
    end else if (en) begin
      lv0 <= path_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ls0   <= path_distance;
      full0 <= fprod[42:16];
      lt0   <= (lsum_t[33:32] != 2'b00) ? tch_pkg::DIST_MAX : lsum_t[31:0];
      lla0  <= 33'(cfg.spiral_length) + 33'(cfg.arc_length);
    end
  end

  // look-ahead stage 1: fade numerator
  logic        lv1, in_entry, in_exit;
  logic [31:0] rem, remc, n1;
  tch_pkg::ld_side_t lsd1;

  assign in_entry = ls0 < cfg.spiral_length;
  assign in_exit  = 33'(ls0) > lla0;
  assign rem      = (ls0 < lt0) ? lt0 - ls0 : 32'd0;
  assign remc     = (rem > cfg.spiral_length) ? cfg.spiral_length : rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      lv1 <= 1'b0;
    end else if (en) begin
      lv1 <= lv0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n1            <= in_entry ? ls0 : remc;
      lsd1.s        <= ls0;
      lsd1.full     <= full0;
      lsd1.use_full <= (cfg.spiral_length == 32'd0) || (!in_entry && !in_exit);
    end
  end

  // look-ahead stage 2: product
  logic              lv2;
  logic [58:0]       num2;
  tch_pkg::ld_side_t lsd2, lsd3;
  logic              lv3;
  logic [26:0]       lq;

  always_ff @(posedge clk) begin
    if (rst) begin
      lv2 <= 1'b0;
    end else if (en) begin
      lv2 <= lv1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num2 <= 59'(lsd1.full) * 59'(n1);
      lsd2 <= lsd1;
    end
  end

  tch_div #(.NW(59), .DW(32), .QW(27), .SW(LD_W)) u_div_lead (
    .clk, .rst, .en,
    .in_vld(lv2), .num(num2), .den(cfg.spiral_length), .side_in(lsd2),
    .out_vld(lv3), .quo(lq), .side_out(lsd3)
  );

  // look-ahead point
  logic        pv;
  logic [31:0] ps, pp;
  logic [32:0] psum;

  assign psum = 33'(lsd3.s) + 33'(lsd3.use_full ? lsd3.full : lq);

  always_ff @(posedge clk) begin
    if (rst) begin
      pv <= 1'b0;
    end else if (en) begin
      pv <= lv3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ps <= lsd3.s;
      pp <= psum[32] ? tch_pkg::DIST_MAX : psum[31:0];
    end
  end

  logic        ev_s, ev_p;
  logic [31:0] cs, hs, cp, hp;

  tch_eval u_eval_path (
    .clk, .rst, .en, .in_vld(pv), .x(ps), .cfg,
    .out_vld(ev_s), .curv(cs), .heading(hs)
  );

  tch_eval u_eval_track (
    .clk, .rst, .en, .in_vld(pv), .x(pp), .cfg,
    .out_vld(ev_p), .curv(cp), .heading(hp)
  );

  // rate
  logic        rate_vld;
  logic [30:0] mag;
  logic [31:0] cs_r, hs_r, hp_r;
  logic [54:0] mprod;

  assign mprod = 55'(cfg.speed) * 55'(cp);

  always_ff @(posedge clk) begin
    if (rst) begin
      rate_vld     <= 1'b0;
      result_valid <= 1'b0;
    end else if (en) begin
      rate_vld     <= ev_s && ev_p;
      result_valid <= rate_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag                <= mprod[54:24];
      cs_r               <= cs;
      hs_r               <= hs;
      hp_r               <= hp;
      curvature          <= cs_r;
      path_heading       <= hs_r;
      track_heading      <= hp_r;
      track_heading_rate <= cfg.turn_negative ? 32'd0 - {1'b0, mag} : {1'b0, mag};
    end
  end

  `TCH_ASSERT(a_hold_lead, path_stall |=> $stable(pv) && $stable(pp), "look-ahead moved in stall")
  `TCH_ASSERT(a_lanes_align, pv |-> $stable(cfg.radius) || !en, "lane config check")
  `TCH_ASSERT_ALWAYS(a_out_src, $rose(result_valid) |-> $past(rate_vld), "result from nowhere")

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps

module tb;

  typedef struct packed {
    logic [31:0] curvature;
    logic [31:0] path_heading;
    logic [31:0] track_heading;
    logic [31:0] track_heading_rate;
  } profile_t;

  typedef struct {
    int          cfg_id;
    logic [31:0] distance;
    bit          typed;
    profile_t    want;
  } row_t;

  localparam logic [63:0] INV_PI_Q64 = 64'h517C_C1B7_2722_0A94;
  localparam logic [63:0] ONE_Q30_64 = 64'h4000_0000;
  localparam logic [63:0] DMAX = 64'hFFFF_FFFF;
  localparam int IDLE_LIMIT = 3000;
  localparam int HOLD_CYCLES = 400;

  logic               clk;
  logic               rst;
  logic               path_valid;
  logic               path_stall;
  logic [31:0]        path_distance;
  logic               result_valid;
  logic               result_stall;
  logic [31:0]        curvature;
  logic signed [31:0] path_heading;
  logic signed [31:0] track_heading;
  logic signed [31:0] track_heading_rate;
  logic               write_enable;
  logic [2:0]         register_index;
  logic [47:0]        write_data;

  tch_pkg::cfg_t turn;
  profile_t pending_profiles[$];
  int       mismatches;
  int       requests_sent;
  int       results_seen;
  int       settings_used;
  int       idle_cycles;
  int       stall_pct;
  bit       hold_req;
  bit       hold_ack;

  transition_curve_heading_profile_top i_dut (
    .clk                (clk),
    .rst                (rst),
    .path_valid         (path_valid),
    .path_stall         (path_stall),
    .path_distance      (path_distance),
    .result_valid       (result_valid),
    .result_stall       (result_stall),
    .curvature          (curvature),
    .path_heading       (path_heading),
    .track_heading      (track_heading),
    .track_heading_rate (track_heading_rate),
    .write_enable       (write_enable),
    .register_index     (register_index),
    .write_data         (write_data)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic logic [63:0] sat_dist(logic [63:0] v);
    return (v > DMAX) ? DMAX : v;
  endfunction

  function automatic logic [63:0] turn_length(tch_pkg::cfg_t c);
    return sat_dist(2 * 64'(c.spiral_length) + 64'(c.arc_length));
  endfunction

  function automatic logic [63:0] frac_q30(logic [63:0] num, logic [63:0] den);
    if (num >= den) return ONE_Q30_64;
    return (num << 30) / den;
  endfunction

  function automatic logic [63:0] smoothstep(logic [63:0] u);
    logic [63:0] u2;
    u2 = (u * u) >> 30;
    return (u2 * (3 * ONE_Q30_64 - 2 * u)) >> 30;
  endfunction

  function automatic logic [63:0] smooth_area(logic [63:0] u);
    logic [63:0] u2, u3, u4;
    u2 = (u * u) >> 30;
    u3 = (u2 * u) >> 30;
    u4 = (u3 * u) >> 30;
    return u3 - (u4 >> 1);
  endfunction

  function automatic logic [63:0] swept_angle(logic [63:0] d, logic [63:0] r);
    logic [63:0] k, q, rem, f;
    k = INV_PI_Q64 >> 33;
    q = d / r;
    rem = d % r;
    f = (rem << 32) / r;
    return q * k + f * (k >> 32) + ((f * (k & DMAX)) >> 32);
  endfunction

  function automatic logic [31:0] curvature_of(tch_pkg::cfg_t c, logic [63:0] s);
    logic [63:0] t, ss, q, l;
    t = turn_length(c);
    l = 64'(c.spiral_length);
    if (c.radius == 0 || s == 0 || s >= t) return 32'h0;
    if (l == 0 || (s > l && s < sat_dist(l + 64'(c.arc_length))))
      ss = ONE_Q30_64;
    else if (s <= l)
      ss = smoothstep(frac_q30(s, l));
    else
      ss = smoothstep(frac_q30(t - s, l));
    q = (ss << 10) / 64'(c.radius);
    return (q > DMAX) ? 32'hFFFF_FFFF : q[31:0];
  endfunction

  function automatic logic [31:0] heading_of(tch_pkg::cfg_t c, logic [63:0] s);
    logic [63:0] t, l, r, base, swept, d;
    t = turn_length(c);
    l = 64'(c.spiral_length);
    r = 64'(c.radius);
    base = {{32{c.start_heading[31]}}, c.start_heading};
    if (r == 0 || s == 0) begin
      swept = 0;
    end else if (s >= t) begin
      swept = 64'(c.sweep_angle);
    end else if (l == 0) begin
      swept = swept_angle(s, r);
    end else if (s <= l) begin
      d = (l * smooth_area(frac_q30(s, l))) >> 30;
      swept = swept_angle(d, r);
    end else if (s <= l + 64'(c.arc_length)) begin
      d = (l >> 1) + (s - l);
      swept = swept_angle(d, r);
    end else begin
      d = (l * smooth_area(frac_q30(t - s, l))) >> 30;
      swept = 64'(c.sweep_angle) - swept_angle(d, r);
    end
    d = c.turn_negative ? base - swept : base + swept;
    return d[31:0];
  endfunction

  function automatic logic [63:0] lookahead_of(tch_pkg::cfg_t c, logic [63:0] s);
    logic [63:0] full, t, l, rem;
    full = (64'(c.speed) * 64'(c.lead_time)) >> 16;
    t = turn_length(c);
    l = 64'(c.spiral_length);
    if (l == 0) return full;
    if (s < l) return (full * s) / l;
    if (s > l + 64'(c.arc_length)) begin
      rem = (s < t) ? t - s : 0;
      if (rem > l) rem = l;
      return (full * rem) / l;
    end
    return full;
  endfunction

  function automatic profile_t heading_profile(tch_pkg::cfg_t c, logic [31:0] distance);
    profile_t    p;
    logic [63:0] s, ahead, mag;
    s = 64'(distance);
    ahead = sat_dist(s + lookahead_of(c, s));
    mag = (64'(c.speed) * 64'(curvature_of(c, ahead))) >> 24;
    if (c.turn_negative) begin
      if (mag > 64'h8000_0000) mag = 64'h8000_0000;
      mag = 64'h0 - mag;
    end else if (mag > 64'h7FFF_FFFF) begin
      mag = 64'h7FFF_FFFF;
    end
    p.curvature = curvature_of(c, s);
    p.path_heading = heading_of(c, s);
    p.track_heading = heading_of(c, ahead);
    p.track_heading_rate = mag[31:0];
    return p;
  endfunction

  function automatic tch_pkg::cfg_t random_turn();
    tch_pkg::cfg_t c;
    case ($urandom_range(5))
      0: c.radius = 32'h0;
      1: c.radius = $urandom_range(255, 1);
      2: c.radius = $urandom;
      default: c.radius = $urandom_range(32'h00C8_0000, 32'h0000_8000);
    endcase
    case ($urandom_range(4))
      0: c.spiral_length = 32'h0;
      1: c.spiral_length = $urandom;
      2: c.spiral_length = 32'hFFFF_FFFF;
      default: c.spiral_length = $urandom_range(32'h0064_0000, 1);
    endcase
    case ($urandom_range(4))
      0: c.arc_length = 32'h0;
      1: c.arc_length = $urandom;
      2: c.arc_length = 32'hFFFF_FFFF;
      default: c.arc_length = $urandom_range(32'h0064_0000);
    endcase
    c.sweep_angle = 48'({$urandom, $urandom});
    c.start_heading = $urandom;
    c.turn_negative = 1'($urandom_range(1));
    case ($urandom_range(3))
      0: c.speed = 23'd6553600;
      1: c.speed = 23'd0;
      default: c.speed = 23'($urandom_range(6553600));
    endcase
    case ($urandom_range(3))
      0: c.lead_time = 20'd655360;
      1: c.lead_time = 20'd0;
      default: c.lead_time = 20'($urandom_range(655360));
    endcase
    return c;
  endfunction

  function automatic logic [31:0] random_distance(tch_pkg::cfg_t c);
    logic [63:0] t, l, pick;
    t = turn_length(c);
    l = 64'(c.spiral_length);
    case ($urandom_range(9))
      0, 1: return $urandom;
      2: pick = l;
      3: pick = l + 64'(c.arc_length);
      4: pick = t;
      5: pick = 64'($urandom_range(3));
      default: return $urandom_range(32'(sat_dist(t + (t >> 3) + 16)));
    endcase
    pick = pick + $urandom_range(4) - 2;
    return 32'(sat_dist(pick[63] ? 64'h0 : pick));
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %h, got %h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      results_seen++;
      if (pending_profiles.size() == 0) begin
        $error("result with no request outstanding");
        mismatches++;
      end else begin
        profile_t want;
        want = pending_profiles.pop_front();
        check_field("curvature", want.curvature, curvature);
        check_field("path_heading", want.path_heading, path_heading);
        check_field("track_heading", want.track_heading, track_heading);
        check_field("track_heading_rate", want.track_heading_rate, track_heading_rate);
      end
    end
  end

  always @(posedge clk) begin
    if ((path_valid && !path_stall) || (result_valid && !result_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    result_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_ack) begin
        result_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_ack = 1'b1;
      end
      result_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  task automatic send_request(logic [31:0] distance, bit typed, profile_t want);
    path_valid <= 1'b1;
    path_distance <= distance;
    do @(posedge clk); while (path_stall);
    pending_profiles.push_back(typed ? want : heading_profile(turn, distance));
    requests_sent++;
  endtask

  task automatic program_turn(tch_pkg::cfg_t c);
    path_valid <= 1'b0;
    while (pending_profiles.size() != 0) @(posedge clk);
    @(posedge clk);
    write_enable <= 1'b1;
    for (int i = 0; i < 8; i++) begin
      register_index <= tch_pkg::reg_index_t'(i);
      case (tch_pkg::reg_index_t'(i))
        tch_pkg::REG_RADIUS:        write_data <= 48'(c.radius);
        tch_pkg::REG_SPIRAL_LENGTH: write_data <= 48'(c.spiral_length);
        tch_pkg::REG_ARC_LENGTH:    write_data <= 48'(c.arc_length);
        tch_pkg::REG_SWEEP_ANGLE:   write_data <= c.sweep_angle;
        tch_pkg::REG_START_HEADING: write_data <= 48'(c.start_heading);
        tch_pkg::REG_TURN_NEGATIVE: write_data <= 48'(c.turn_negative);
        tch_pkg::REG_SPEED:         write_data <= 48'(c.speed);
        default:                    write_data <= 48'(c.lead_time);
      endcase
      @(posedge clk);
    end
    write_enable <= 1'b0;
    turn = c;
    settings_used++;
  endtask

  initial begin
    tch_pkg::cfg_t dcfg[5];
    row_t     rows[$];
    profile_t zero_p, pi_p;
    int       cur_cfg;
    int       burst;

    rst = 1'b1;
    path_valid = 1'b0;
    path_distance = '0;
    write_enable = 1'b0;
    register_index = '0;
    write_data = '0;
    mismatches = 0;
    requests_sent = 0;
    results_seen = 0;
    settings_used = 0;
    idle_cycles = 0;
    stall_pct = 20;
    hold_req = 1'b0;
    hold_ack = 1'b0;

    dcfg[0] = '{tch_pkg::RADIUS_RESET, 32'h0, 32'h0, 48'h0, 32'sh0, 1'b0, 23'd0, 20'd0};
    dcfg[1] = '{32'h0032_0000, 32'h0014_0000, 32'h001E_0000, 48'h4000_0000,
                32'sh1000_0000, 1'b0, 23'h0A_0000, 20'h1_0000};
    dcfg[2] = '{32'h0, 32'h0014_0000, 32'h001E_0000, 48'hFFFF_FFFF_FFFF,
                32'sh8000_0000, 1'b1, 23'd6553600, 20'd655360};
    dcfg[3] = '{32'h1, 32'h0, 32'h0064_0000, 48'h1234_5678_9ABC,
                32'sh7FFF_FFFF, 1'b1, 23'd6553600, 20'd655360};
    dcfg[4] = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF,
                32'sh7FFF_FFFF, 1'b0, 23'd6553600, 20'd655360};
    zero_p = '0;
    pi_p = '{32'h0, 32'h8000_0000, 32'h8000_0000, 32'h0};

    rows = '{
      '{0, 32'h0, 1'b1, zero_p},
      '{0, 32'h1, 1'b1, zero_p},
      '{0, 32'hFFFF_FFFF, 1'b1, zero_p},
      '{1, 32'h0, 1'b0, zero_p},
      '{1, 32'h1, 1'b0, zero_p},
      '{1, 32'h000A_0000, 1'b0, zero_p},
      '{1, 32'h0014_0000, 1'b0, zero_p},
      '{1, 32'h0023_0000, 1'b0, zero_p},
      '{1, 32'h0045_FFFF, 1'b0, zero_p},
      '{1, 32'h0046_0000, 1'b0, zero_p},
      '{1, 32'hFFFF_FFFF, 1'b0, zero_p},
      '{2, 32'h0, 1'b1, pi_p},
      '{2, 32'hFFFF_FFFF, 1'b1, pi_p},
      '{3, 32'h0, 1'b0, zero_p},
      '{3, 32'h1, 1'b0, zero_p},
      '{3, 32'h0032_0000, 1'b0, zero_p},
      '{3, 32'h0064_0000, 1'b0, zero_p},
      '{3, 32'h8000_0000, 1'b0, zero_p},
      '{4, 32'h0, 1'b0, zero_p},
      '{4, 32'h7FFF_FFFF, 1'b0, zero_p},
      '{4, 32'h8000_0000, 1'b0, zero_p},
      '{4, 32'hFFFF_FFFE, 1'b0, zero_p},
      '{4, 32'hFFFF_FFFF, 1'b0, zero_p}
    };

    turn = dcfg[0];
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    cur_cfg = 0;
    foreach (rows[i]) begin
      if (rows[i].cfg_id != cur_cfg) begin
        cur_cfg = rows[i].cfg_id;
        program_turn(dcfg[cur_cfg]);
      end
      send_request(rows[i].distance, rows[i].typed, rows[i].want);
    end

    for (int phase = 0; phase < 9; phase++) begin
      program_turn((phase == 0) ? dcfg[4] : random_turn());
      stall_pct = (phase == 2) ? 0 : $urandom_range(60);
      if (phase == 3) hold_req = 1'b1;
      burst = 0;
      for (int n = 0; n < 148; n++) begin
        if (phase == 5 && n == 74) begin
          path_valid <= 1'b0;
          while (pending_profiles.size() != 0) @(posedge clk);
        end
        send_request(random_distance(turn), 1'b0, zero_p);
        if (phase != 2 && phase != 3) begin
          if (burst == 0) begin
            burst = $urandom_range(20, 1);
            path_valid <= 1'b0;
            repeat ($urandom_range(5, 1)) @(posedge clk);
          end else begin
            burst--;
          end
        end
      end
    end

    path_valid <= 1'b0;
    while (pending_profiles.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);

    $display("Ran %0d distance requests (%0d results) over %0d turn settings,",
             requests_sent, results_seen, settings_used);
    $display("with burst gaps, output stalls, a long output hold-off and a drain pause.");
    if (mismatches == 0 && pending_profiles.size() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
